>>> hdl/tlbflr_pkg.sv
// Shared types, constants and codes for the translation lookaside store.
// No dependencies; every other file of the block imports this package.
package tlbflr_pkg;

    localparam int MAX_ENTRIES = 8;
    localparam int PAGE_BITS   = 20;
    localparam int FRAME_BITS  = 20;

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    localparam int ACTION_W = 2;
    localparam int CFG_W    = 4;
    localparam int CFG_IDX_W = 1;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_FLUSH  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_POLICY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES_IN_USE = 1'd1;

    localparam logic [CFG_W-1:0] ENTRIES_IN_USE_RESET = 4'd8;

    typedef struct packed {
        logic [ACTION_W-1:0]   action;
        logic [PAGE_BITS-1:0]  page_number;
        logic [FRAME_BITS-1:0] frame_number;
    } tlbflr_in_t;

    typedef struct packed {
        logic                  hit;
        logic [FRAME_BITS-1:0] frame_found;
    } tlbflr_out_t;

    typedef enum logic {
        ST_IDLE,
        ST_UPDATE
    } tlbflr_state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;  // latch the item and the search result
        logic commit;   // update the entries and load the result register
    } tlbflr_cmd_t;

endpackage

>>> hdl/tlb_lookup_with_fifo_lru_replace_unit.sv
// Top level of the fully associative translation store with FIFO/LRU order.
// Depends on tlbflr_pkg, tlbflr_ctrl and tlbflr_dp.
//
// Usage:
//   s_valid/s_ready/s_item carry one item: action (lookup, insert, flush),
//   page_number and frame_number. m_valid/m_ready/m_item return one result
//   item per input item: hit and frame_found (zero on miss, insert, flush
//   or the unused action code).
//   cfg_we/cfg_index/cfg_wdata write replace_policy (index 0) and
//   entries_in_use (index 1); write only while the block is idle.
// Sequence:
//   An item is searched against all entries in the cycle it is accepted;
//   the update state then shifts the entry registers and loads the result
//   register once it is free. The next item is taken only after that update,
//   set by the search-then-shift sequence over one entry file.
// Reset (aresetn low, synchronous): the store is empty, FIFO order, eight
//   entries in use, no result pending.
// Stall: a finished result waits in the output register while the next item
//   is accepted and searched; its update holds until the result register
//   drains.
module tlb_lookup_with_fifo_lru_replace_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  tlbflr_pkg::tlbflr_in_t            s_item,
    output logic                              m_valid,
    input  logic                              m_ready,
    output tlbflr_pkg::tlbflr_out_t           m_item,
    input  logic                              cfg_we,
    input  logic [tlbflr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tlbflr_pkg::CFG_W-1:0]      cfg_wdata
);
    import tlbflr_pkg::*;

    tlbflr_cmd_t cmd;

    // Sequence capture and commit of each item
    tlbflr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // Hold the entries, search, shift and drive the result
    tlbflr_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .s_item    (s_item),
        .m_item    (m_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

endmodule

>>> hdl/tlbflr_ctrl.sv
// Controller state machine: sequences capture and commit, owns the result valid.
// Depends on tlbflr_pkg.
module tlbflr_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  logic                   m_ready,
    output tlbflr_pkg::tlbflr_cmd_t cmd
);
    import tlbflr_pkg::*;

    tlbflr_state_t state_reg, state_next;
    logic          m_valid_reg, m_valid_next;
    logic          out_free;

    // The result register can take a new item when empty or draining
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready     = 1'b0;
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            ST_UPDATE: begin
                cmd.commit = out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

>>> hdl/tlbflr_dp.sv
// Datapath: entry registers in recency order, parallel search, shifts,
// configuration registers and the result register. Depends on tlbflr_pkg.
module tlbflr_dp (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  tlbflr_pkg::tlbflr_cmd_t     cmd,
    input  tlbflr_pkg::tlbflr_in_t      s_item,
    output tlbflr_pkg::tlbflr_out_t     m_item,
    input  logic                        cfg_we,
    input  logic [tlbflr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tlbflr_pkg::CFG_W-1:0]     cfg_wdata
);
    import tlbflr_pkg::*;

    logic [PAGE_BITS-1:0]  page_reg  [MAX_ENTRIES];
    logic [PAGE_BITS-1:0]  page_next [MAX_ENTRIES];
    logic [FRAME_BITS-1:0] frame_reg [MAX_ENTRIES];
    logic [FRAME_BITS-1:0] frame_next[MAX_ENTRIES];
    logic [CNT_W-1:0]      count_reg, count_next;

    logic                  policy_reg;
    logic [CFG_W-1:0]      eiu_reg;

    tlbflr_in_t            item_reg;
    logic                  hit_reg;
    logic [IDX_W-1:0]      idx_reg;
    tlbflr_out_t           result_reg;

    logic                  search_hit;
    logic [IDX_W-1:0]      search_idx;
    logic [31:0]           cap_wide;
    logic [CNT_W-1:0]      cap;
    logic [CNT_W-1:0]      shift_lim;
    tlbflr_out_t           result_next;

    // Search the valid front of the list; the lowest position wins
    always_comb begin
        search_hit = 1'b0;
        search_idx = '0;
        for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
            if ((CNT_W'(i) < count_reg) && (page_reg[i] == s_item.page_number)) begin
                search_hit = 1'b1;
                search_idx = IDX_W'(i);
            end
        end
    end

    // Capacity: zero counts as one, saturate at the store depth
    always_comb begin
        cap_wide = {{(32-CFG_W){1'b0}}, eiu_reg};
        if (cap_wide == 32'd0) begin
            cap = CNT_W'(1);
        end else if (cap_wide > 32'(MAX_ENTRIES)) begin
            cap = CNT_W'(MAX_ENTRIES);
        end else begin
            cap = cap_wide[CNT_W-1:0];
        end
        shift_lim = (count_reg < cap) ? count_reg : (count_reg - CNT_W'(1));
    end

    always_comb begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            page_next[i]  = page_reg[i];
            frame_next[i] = frame_reg[i];
        end
        count_next  = count_reg;
        result_next = '0;
        case (item_reg.action)
            ACT_LOOKUP: begin
                if (hit_reg) begin
                    result_next.hit         = 1'b1;
                    result_next.frame_found = frame_reg[idx_reg];
                    if (policy_reg) begin
                        // Move the hit entry to the front
                        for (int i = 1; i < MAX_ENTRIES; i++) begin
                            if (IDX_W'(i) <= idx_reg) begin
                                page_next[i]  = page_reg[i-1];
                                frame_next[i] = frame_reg[i-1];
                            end
                        end
                        page_next[0]  = page_reg[idx_reg];
                        frame_next[0] = frame_reg[idx_reg];
                    end
                end
            end
            ACT_INSERT: begin
                // Open the front; drop the last entry when full
                for (int i = 1; i < MAX_ENTRIES; i++) begin
                    if (CNT_W'(i) <= shift_lim) begin
                        page_next[i]  = page_reg[i-1];
                        frame_next[i] = frame_reg[i-1];
                    end
                end
                page_next[0]  = item_reg.page_number;
                frame_next[0] = item_reg.frame_number;
                if (count_reg < cap) begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            ACT_FLUSH: begin
                count_next = '0;
            end
            default: begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            policy_reg <= 1'b0;
            eiu_reg    <= ENTRIES_IN_USE_RESET;
        end else begin
            if (cmd.commit) begin
                count_reg <= count_next;
            end
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_REPLACE_POLICY: policy_reg <= cfg_wdata[0];
                    CFG_ENTRIES_IN_USE: eiu_reg    <= cfg_wdata;
                    default:            eiu_reg    <= eiu_reg;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            item_reg <= s_item;
            hit_reg  <= search_hit;
            idx_reg  <= search_idx;
        end
        if (cmd.commit) begin
            result_reg <= result_next;
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                page_reg[i]  <= page_next[i];
                frame_reg[i] <= frame_next[i];
            end
        end
    end

    assign m_item = result_reg;

endmodule

>>> hdl/tlbflr_checker.sv
// Port-level checker for the translation store, bound to the top level.
// Depends on tlbflr_pkg and tlb_lookup_with_fifo_lru_replace_unit.
module tlbflr_checker (
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_valid,
    input logic                    s_ready,
    input logic                    m_valid,
    input logic                    m_ready,
    input tlbflr_pkg::tlbflr_out_t m_item
);
    import tlbflr_pkg::*;

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result changed while stalled");

    // One item in flight: no accept in the cycle after an accept
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("item accepted while previous item in flight");

    // A miss carries a zero frame
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_item.hit |-> m_item.frame_found == '0)
        else $error("nonzero frame without hit");

    // Reset leaves no result pending
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind tlb_lookup_with_fifo_lru_replace_unit tlbflr_checker u_tlbflr_checker (.*);
